/* src/first_fit_heap_allocator_unit_defines.svh */
// Assertion macros for the first-fit heap allocator.
// Used by the port checker; needs no other file.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define FFHA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define FFHA_ASSERT_NEXT(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) else $error(msg);

`endif

/* src/ffha_pkg.sv */
// Shared types, codes and helpers of the first-fit heap allocator.
// Used by the top level, the free-list RAM and the port checker.
package ffha_pkg;

  localparam logic [16:0] HdrBytes = 17'd8;
  localparam logic [16:0] MinChunk = 17'd24;
  localparam logic [16:0] AlignLow = 17'hf;

  localparam logic       ActAlloc = 1'b0;
  localparam logic       ActFree  = 1'b1;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatNoFit = 2'd1;
  localparam logic [1:0] StatFull  = 2'd2;

  typedef struct packed {
    logic        action;
    logic [15:0] request_bytes;
    logic [15:0] user_offset;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_offset;
    logic [16:0] granted_bytes;
  } out_word_t;

  // One free-list entry: chunk offset and chunk size.
  typedef struct packed {
    logic [15:0] offset;
    logic [16:0] size;
  } fl_entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_TAIL,
    ST_FREE
  } ffha_state_e;

  // Request plus header, at least the minimum chunk, else 16-byte aligned.
  function automatic logic [16:0] round_request(logic [15:0] req);
    logic [16:0] s;
    s = {1'b0, req} + HdrBytes;
    if (s <= MinChunk) begin
      return MinChunk;
    end
    return (s + AlignLow) & ~AlignLow;
  endfunction

endpackage

/* src/ffha_list_ram.sv */
// Free-list storage: a circular RAM addressed by list position from the head.
// Depends on ffha_pkg for the entry type.
module ffha_list_ram import ffha_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic [$clog2(DEPTH)-1:0]      head_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(DEPTH+2)-1:0]    wr_pos_i,
  input  fl_entry_t                     wr_data_i,
  input  logic [$clog2(DEPTH+2)-1:0]    rd_pos_i,
  output fl_entry_t                     rd_data_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 2);
  localparam int SW = PW + 1;
  localparam logic [SW-1:0] Depth = SW'(DEPTH);

  fl_entry_t mem [DEPTH];

  logic [SW-1:0] wr_sum, rd_sum;
  logic [IW-1:0] wr_addr, rd_addr;

  // Position plus head, wrapped once around the ring.
  always_comb begin
    wr_sum = SW'(head_i) + SW'(wr_pos_i);
    rd_sum = SW'(head_i) + SW'(rd_pos_i);
    if (wr_sum >= Depth) begin
      wr_sum = wr_sum - Depth;
    end
    if (rd_sum >= Depth) begin
      rd_sum = rd_sum - Depth;
    end
    wr_addr = wr_sum[IW-1:0];
    rd_addr = rd_sum[IW-1:0];
  end

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr];
  end

endmodule

/* src/first_fit_heap_allocator_unit.sv */
// First-fit heap allocator. One word in gives one word out. A free reads the
// size table, then writes the list; a free that finds the list full answers
// straight from the idle state, and so does an allocate that finds the list
// empty. An allocate walks the free list one entry per cycle through the list
// RAM's read port until a chunk fits, then closes the gap by moving every later
// entry one place forward, one entry per cycle, and finishes in the tail state.
// After reset the block writes the initial chunk before it takes its first
// word.
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
  parameter int HEAP_BYTES      = 65536,
  parameter int MAX_FREE_CHUNKS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int IW = $clog2(MAX_FREE_CHUNKS);
  localparam int CW = $clog2(MAX_FREE_CHUNKS + 1);
  localparam int PW = $clog2(MAX_FREE_CHUNKS + 2);
  localparam int TDEPTH = HEAP_BYTES / 8;
  localparam int TW = $clog2(TDEPTH);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_FREE_CHUNKS);
  localparam logic [IW-1:0] LastSlot = IW'(MAX_FREE_CHUNKS - 1);
  localparam logic [PW-1:0] PrevPos  = PW'(MAX_FREE_CHUNKS - 1);
  localparam logic [16:0]   HeapSize = 17'(HEAP_BYTES);
  localparam logic [15:0]   TblDepth = 16'(TDEPTH);

  ffha_state_e state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [16:0]   need_q, need_d;
  logic [15:0]   off_q, off_d;
  logic [16:0]   size_q, size_d;
  logic [15:0]   coff_q, coff_d;
  logic          out_valid_q, out_valid_d;
  out_word_t     out_q, out_d;

  logic          wr_en;
  logic [PW-1:0] wr_pos, rd_pos;
  fl_entry_t     wr_data, rd_data;

  logic [16:0]   tbl [TDEPTH];
  logic [16:0]   tbl_rdata_q;
  logic          tbl_we;
  logic [16:0]   tbl_wdata;
  logic [15:0]   in_coff;
  logic [16:0]   rem;
  logic [16:0]   csize;

  ffha_list_ram #(
    .DEPTH (MAX_FREE_CHUNKS)
  ) u_list (
    .clk_i     (clk_i),
    .head_i    (head_q),
    .wr_en_i   (wr_en),
    .wr_pos_i  (wr_pos),
    .wr_data_i (wr_data),
    .rd_pos_i  (rd_pos),
    .rd_data_o (rd_data)
  );

  assign in_coff = in_word_i.user_offset - 16'd8;
  assign rem     = size_q - need_q;
  assign csize   = ({3'b000, coff_q[15:3]} < TblDepth) ? tbl_rdata_q : 17'd0;

  // Chunk size table: written when an allocate completes, read for a free.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl[off_q[TW+2:3]] <= tbl_wdata;
    end
    tbl_rdata_q <= tbl[in_coff[TW+2:3]];
  end

  // Control registers, reset asynchronously; the payload registers below have no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      head_q      <= '0;
      count_q     <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    need_q <= need_d;
    off_q  <= off_d;
    size_q <= size_d;
    coff_q <= coff_d;
    out_q  <= out_d;
  end

  // Sequencer: write the initial chunk, search, close the gap, append the remainder, or push a free.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    need_d      = need_q;
    off_d       = off_q;
    size_d      = size_q;
    coff_d      = coff_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_pos      = '0;
    wr_data     = '0;
    rd_pos      = PW'(idx_q) + PW'(1);
    tbl_we      = 1'b0;
    tbl_wdata   = '0;
    in_ready_o  = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_data = '{offset: 16'd0, size: HeapSize};
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = ~out_valid_q | out_ready_i;
        rd_pos     = '0;
        if (in_valid_i && in_ready_o) begin
          if (in_word_i.action == ActFree) begin
            if (count_q >= MaxCount) begin
              out_valid_d = 1'b1;
              out_d       = '{status: StatFull, granted_offset: '0, granted_bytes: '0};
            end else begin
              coff_d  = in_coff;
              state_d = ST_FREE;
            end
          end else begin
            need_d = round_request(in_word_i.request_bytes);
            idx_d  = '0;
            if (count_q == '0) begin
              out_valid_d = 1'b1;
              out_d       = '{status: StatNoFit, granted_offset: '0, granted_bytes: '0};
            end else begin
              state_d = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        // Data of position idx is back; the next position is read meanwhile.
        if (rd_data.size >= need_q) begin
          off_d  = rd_data.offset;
          size_d = rd_data.size;
          state_d = (idx_q == count_q - CW'(1)) ? ST_TAIL : ST_SHIFT;
        end else if (idx_q == count_q - CW'(1)) begin
          out_valid_d = 1'b1;
          out_d       = '{status: StatNoFit, granted_offset: '0, granted_bytes: '0};
          state_d     = ST_IDLE;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      ST_SHIFT: begin
        // Move entry idx+1 into idx while reading idx+2.
        wr_en   = 1'b1;
        wr_pos  = PW'(idx_q);
        wr_data = rd_data;
        rd_pos  = PW'(idx_q) + PW'(2);
        idx_d   = idx_q + CW'(1);
        if (PW'(idx_q) + PW'(2) == PW'(count_q)) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        tbl_we = ({3'b000, off_q[15:3]} < TblDepth);
        if (rem >= MinChunk) begin
          wr_en     = 1'b1;
          wr_pos    = PW'(count_q - CW'(1));
          wr_data   = '{offset: off_q + need_q[15:0], size: rem};
          tbl_wdata = need_q;
        end else begin
          count_d   = count_q - CW'(1);
          tbl_wdata = size_q;
        end
        out_valid_d = 1'b1;
        out_d       = '{status: StatOk, granted_offset: off_q + 16'd8,
                        granted_bytes: tbl_wdata};
        state_d     = ST_IDLE;
      end
      ST_FREE: begin
        // Push onto the head: one slot before the current head.
        wr_en       = 1'b1;
        wr_pos      = PrevPos;
        wr_data     = '{offset: coff_q, size: csize};
        head_d      = (head_q == '0) ? LastSlot : head_q - IW'(1);
        count_d     = count_q + CW'(1);
        out_valid_d = 1'b1;
        out_d       = '{status: StatOk, granted_offset: '0, granted_bytes: '0};
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* src/ffha_checker.sv */
// Port checker for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and the assertion macro header.
`include "first_fit_heap_allocator_unit_defines.svh"

module ffha_checker import ffha_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // A stalled result word stays and keeps its payload.
  `FFHA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o), "result word dropped or changed while stalled")

  // No new word is taken while a result waits and is not taken.
  `FFHA_ASSERT(a_no_accept_blocked, clk_i, rst_ni, !(out_valid_o && !out_ready_i && in_ready_o), "input ready while result is stalled")

  // A failed allocate carries no offset and no size.
  `FFHA_ASSERT(a_nofit_zero, clk_i, rst_ni, !(out_valid_o && out_word_o.status == StatNoFit) || (out_word_o.granted_offset == '0 && out_word_o.granted_bytes == '0), "failed allocate carries data")

  // Only defined status codes appear.
  `FFHA_ASSERT(a_status_code, clk_i, rst_ni, !out_valid_o || out_word_o.status == StatOk || out_word_o.status == StatNoFit || out_word_o.status == StatFull, "undefined status code")

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

/* verif/first_fit_heap_allocator_unit_tb.sv */
// Testbench for the first-fit heap allocator: drives allocate and free words,
// predicts each result with a free-list model of its own and checks it field by field.
// Depends on ffha_pkg and first_fit_heap_allocator_unit.
`timescale 1ns / 100ps

module first_fit_heap_allocator_unit_tb;
  import ffha_pkg::*;

  localparam int HeapBytes  = 65536;
  localparam int MaxChunks  = 256;
  localparam int TableDepth = HeapBytes / 8;
  localparam int CycleLimit = 2000000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  first_fit_heap_allocator_unit #(
    .HEAP_BYTES(HeapBytes),
    .MAX_FREE_CHUNKS(MaxChunks)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o(out_word_o)
  );

  // Predictor state: the free list and the per-chunk size record.
  logic [15:0] list_offset [MaxChunks];
  logic [16:0] list_size [MaxChunks];
  int          list_count;
  logic [16:0] size_record [TableDepth];

  // Stimulus-side view of live allocations, so that frees stay legal.
  logic [15:0] live_user [$];

  in_word_t  pending_words [$];
  out_word_t expected_words [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  idle_enable;
  bit  hold_off_request;
  int  hold_off_left;
  int  send_gap;
  int  recv_gap;
  bit  in_taken;

  // Predicts the result of one word and updates the model's free list.
  function automatic out_word_t heap_predict(in_word_t w);
    out_word_t   r;
    logic [16:0] need;
    logic [16:0] s;
    logic [15:0] off;
    logic [16:0] size;
    logic [15:0] coff;
    int          idx;
    r = '0;
    if (w.action == ActAlloc) begin
      s = {1'b0, w.request_bytes} + 17'd8;
      need = (s <= 17'd24) ? 17'd24 : ((s + 17'hf) & ~17'hf);
      for (int i = 0; i < list_count; i++) begin
        if (list_size[i] >= need) begin
          off = list_offset[i];
          size = list_size[i];
          for (int k = i; k + 1 < list_count; k++) begin
            list_offset[k] = list_offset[k + 1];
            list_size[k] = list_size[k + 1];
          end
          list_count--;
          if (size - need >= 17'd24) begin
            list_offset[list_count] = off + need[15:0];
            list_size[list_count] = size - need;
            list_count++;
            size = need;
          end
          size_record[off >> 3] = size;
          r.status = StatOk;
          r.granted_offset = off + 16'd8;
          r.granted_bytes = size;
          return r;
        end
      end
      r.status = StatNoFit;
      return r;
    end
    if (list_count >= MaxChunks) begin
      r.status = StatFull;
      return r;
    end
    coff = w.user_offset - 16'd8;
    idx = coff >> 3;
    for (int i = list_count; i > 0; i--) begin
      list_offset[i] = list_offset[i - 1];
      list_size[i] = list_size[i - 1];
    end
    list_offset[0] = coff;
    list_size[0] = size_record[idx];
    list_count++;
    r.status = StatOk;
    return r;
  endfunction

  // Queues one allocate word; a granted user offset becomes freeable later.
  // The model runs at queue time, which is fine since words go in order.
  task automatic push_alloc(logic [15:0] req);
    in_word_t  w;
    out_word_t r;
    w = '0;
    w.action = ActAlloc;
    w.request_bytes = req;
    w.user_offset = 16'($urandom);
    r = heap_predict(w);
    if (r.status == StatOk) live_user.push_back(r.granted_offset);
    pending_words.push_back(w);
    expected_words.push_back(r);
  endtask

  // Queues a free of the live chunk at position pos; a full list keeps it live.
  task automatic push_free(int pos);
    in_word_t  w;
    out_word_t r;
    w = '0;
    w.action = ActFree;
    w.request_bytes = 16'($urandom);
    w.user_offset = live_user[pos];
    r = heap_predict(w);
    if (r.status == StatOk) live_user.delete(pos);
    pending_words.push_back(w);
    expected_words.push_back(r);
  endtask

  // Queues a repeat free of a chunk already on the list (a reused size entry).
  task automatic push_stale_free(logic [15:0] uoff);
    in_word_t  w;
    out_word_t r;
    w = '0;
    w.action = ActFree;
    w.user_offset = uoff;
    r = heap_predict(w);
    pending_words.push_back(w);
    expected_words.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Clock.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Driver: offers the oldest pending word, with random gaps when enabled.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
      send_gap <= 0;
    end else if (in_valid_i && !in_taken) begin
      // Hold the word until it is accepted.
    end else if (send_gap > 0) begin
      in_valid_i <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_words.size() != 0 && idle_enable && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      send_gap <= $urandom_range(0, 5);
    end else if (pending_words.size() != 0) begin
      in_valid_i <= 1'b1;
      in_word_i <= pending_words[0];
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // The pending queue drops its head on acceptance.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) void'(pending_words.pop_front());
  end

  // Receiver ready: long hold-offs on request, random stalls otherwise.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_off_left <= 0;
      recv_gap <= 0;
    end else if (hold_off_request && hold_off_left == 0) begin
      out_ready_i <= 1'b0;
      hold_off_left <= 400;
    end else if (hold_off_left > 1) begin
      out_ready_i <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (recv_gap > 0) begin
      out_ready_i <= 1'b0;
      recv_gap <= recv_gap - 1;
      hold_off_left <= 0;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      recv_gap <= $urandom_range(0, 5);
      hold_off_left <= 0;
    end else begin
      out_ready_i <= 1'b1;
      hold_off_left <= 0;
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_word_t exp_word;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("Unexpected word %h", out_word_o);
      end else begin
        exp_word = expected_words.pop_front();
        if (exp_word.status !== out_word_o.status
            || exp_word.granted_offset !== out_word_o.granted_offset
            || exp_word.granted_bytes !== out_word_o.granted_bytes) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("Mismatch: status %0d/%0d offset %h/%h bytes %h/%h",
                     exp_word.status, out_word_o.status,
                     exp_word.granted_offset, out_word_o.granted_offset,
                     exp_word.granted_bytes, out_word_o.granted_bytes);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL first_fit_heap_allocator_unit");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int          choice;
    int          wait_cycles;
    logic [15:0] stale_user;
    rst_ni = 1'b0;
    idle_enable = 1'b1;
    hold_off_request = 1'b0;
    list_offset[0] = 16'd0;
    list_size[0] = 17'(HeapBytes);
    list_count = 1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: request extremes, rounding edges, exact fits and a miss.
    push_alloc(16'd0);
    push_alloc(16'd16);
    push_alloc(16'd17);
    push_alloc(16'd24);
    push_alloc(16'd25);
    push_alloc(16'hffff);
    push_alloc(16'd40);
    push_free(0);
    push_free(0);
    push_alloc(16'd10);
    push_alloc(16'd100);
    push_free(live_user.size() - 1);
    push_alloc(16'd92);
    push_alloc(16'd2000);
    push_free(0);
    // A chunk on the list whose size entry exists: freeing it again is defined.
    stale_user = list_offset[0] + 16'd8;
    push_stale_free(stale_user);
    push_alloc(16'd64000);
    push_alloc(16'hfff0);
    wait_drained();

    // Fill the list with small pieces until a free reports it full.
    for (int i = 0; i < 260; i++) push_alloc(16'($urandom_range(0, 40)));
    wait_drained();
    hold_off_request = 1'b1;
    for (int i = 0; i < 260 && live_user.size() != 0; i++) begin
      push_free($urandom_range(0, live_user.size() - 1));
    end
    @(posedge clk_i);
    hold_off_request = 1'b0;
    wait_drained();

    // Random mix of allocates and frees of live chunks.
    for (int i = 0; i < 120; i++) begin
      if (i == 90) begin
        wait_drained();
        idle_enable = 1'b0;
      end
      choice = $urandom_range(0, 9);
      if (choice < 5 || live_user.size() == 0) begin
        case ($urandom_range(0, 3))
          0: push_alloc(16'($urandom));
          1: push_alloc(16'($urandom_range(0, 4096)));
          default: push_alloc(16'($urandom_range(0, 200)));
        endcase
      end else begin
        push_free($urandom_range(0, live_user.size() - 1));
      end
    end

    wait_cycles = 0;
    while ((pending_words.size() != 0 || expected_words.size() != 0)
           && wait_cycles < 1000000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (600) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("PASS first_fit_heap_allocator_unit");
    end else begin
      $display("FAIL first_fit_heap_allocator_unit");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/ffha_pkg.sv
src/ffha_list_ram.sv
src/first_fit_heap_allocator_unit.sv
src/ffha_checker.sv
verif/first_fit_heap_allocator_unit_tb.sv
